@@ hw/rtl/skt_pkg.sv @@
// shared types and constants for the sorted key table
// no dependencies
package skt_pkg;

    localparam int SKT_TABLE_DEPTH = 256;
    localparam int SKT_KEY_W       = 32;
    localparam int SKT_VAL_W       = 64;
    localparam int SKT_POS_W       = 8;
    localparam int SKT_ENTRY_W     = SKT_KEY_W + SKT_VAL_W;

    typedef logic [SKT_KEY_W-1:0] t_key;
    typedef logic [SKT_VAL_W-1:0] t_val;
    typedef logic [SKT_POS_W-1:0] t_pos;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

@@ hw/rtl/skt_if.sv @@
// request and response channel interfaces of the sorted key table
// depends on skt_pkg
interface skt_req_if
    import skt_pkg::*;
();
    logic valid;
    logic ready;
    logic operation;
    t_key key;
    t_val entry_value;

    modport source (output valid, output operation, output key, output entry_value,
                    input ready);
    modport sink   (input valid, input operation, input key, input entry_value,
                    output ready);
endinterface

interface skt_rsp_if
    import skt_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    t_pos       position;
    t_val       found_value;

    modport source (output valid, output status, output position, output found_value,
                    input ready);
    modport sink   (input valid, input status, input position, input found_value,
                    output ready);
endinterface

@@ hw/rtl/sorted_key_table_insert_lookup.sv @@
// a lookup binary-searches the n stored entries, alternating the search and compare states
// an insert runs the same search, then moves each entry above the insert position up by one
// before writing the new entry; one request at a time, taken only in the idle state
// synchronous active-low reset empties the table; the ram is never cleared
// a finished result waits in the output register while the next request is taken
// depends on skt_pkg, skt_if, skt_ram
module sorted_key_table_insert_lookup
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = SKT_TABLE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    skt_req_if.sink   i_req,
    skt_rsp_if.source o_rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SRCH  = 5'b00010,
        S_CMP   = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [AW-1:0] r_mid, n_mid;
    logic          r_hit, n_hit;
    t_val          r_hit_val, n_hit_val;
    logic [CW-1:0] r_sh_cnt, n_sh_cnt;
    logic [AW-1:0] r_sh_addr, n_sh_addr;
    logic          r_wr_pend, n_wr_pend;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic          r_op;
    t_key          r_key;
    t_val          r_val;
    t_status       r_st, n_st;
    t_val          r_found, n_found;
    logic          r_o_valid, n_o_valid;
    t_status       r_o_st;
    t_pos          r_o_pos;
    t_val          r_o_found;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SKT_ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [SKT_ENTRY_W-1:0] ram_rdata;
    logic [CW-1:0]          mid;
    t_key                   rd_key;
    logic                   req_xfer;
    logic                   out_load;
    logic [CW+SKT_POS_W-1:0] pos_ext;

    skt_ram #(
        .WIDTH (SKT_ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;
    assign mid         = r_lo + ((r_hi - r_lo) >> 1);
    assign rd_key      = ram_rdata[SKT_ENTRY_W-1:SKT_VAL_W];
    assign out_load    = (r_state == S_DONE) && (!r_o_valid || o_rsp.ready);
    assign pos_ext     = {{SKT_POS_W{1'b0}}, r_lo};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_hit     = r_hit;
        n_hit_val = r_hit_val;
        n_sh_cnt  = r_sh_cnt;
        n_sh_addr = r_sh_addr;
        n_wr_pend = r_wr_pend;
        n_wr_addr = r_wr_addr;
        n_st      = r_st;
        n_found   = r_found;
        n_o_valid = r_o_valid;
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = ram_rdata;
        ram_raddr = r_mid;

        if (o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_hit   = 1'b0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_mid     = mid[AW-1:0];
                    ram_raddr = mid[AW-1:0];
                    n_state   = S_CMP;
                end else begin
                    n_found = '0;
                    if (r_op == OP_LOOKUP) begin
                        n_st    = r_hit ? ST_OK : ST_NOT_FOUND;
                        n_found = r_hit ? r_hit_val : '0;
                        n_state = S_DONE;
                    end else if (r_hit) begin
                        n_st    = ST_DUPLICATE;
                        n_state = S_DONE;
                    end else if (r_count == CW'(TABLE_DEPTH)) begin
                        n_st    = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_st      = ST_OK;
                        n_sh_cnt  = r_count - r_lo;
                        n_sh_addr = AW'(r_count - CW'(1));
                        n_wr_pend = 1'b0;
                        n_state   = S_SHIFT;
                    end
                end
            end
            S_CMP: begin
                if (rd_key < r_key) begin
                    n_lo = {{(CW-AW){1'b0}}, r_mid} + CW'(1);
                end else begin
                    n_hi      = {{(CW-AW){1'b0}}, r_mid};
                    n_hit     = (rd_key == r_key);
                    n_hit_val = ram_rdata[SKT_VAL_W-1:0];
                end
                n_state = S_SRCH;
            end
            S_SHIFT: begin
                ram_raddr = r_sh_addr;
                if (r_wr_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr_addr;
                    ram_wdata = ram_rdata;
                end else if (r_sh_cnt == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[AW-1:0];
                    ram_wdata = {r_key, r_val};
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
                n_wr_pend = (r_sh_cnt != '0);
                n_wr_addr = r_sh_addr + AW'(1);
                if (r_sh_cnt != '0) begin
                    n_sh_addr = r_sh_addr - AW'(1);
                    n_sh_cnt  = r_sh_cnt - CW'(1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_hit     <= n_hit;
        r_hit_val <= n_hit_val;
        r_sh_cnt  <= n_sh_cnt;
        r_sh_addr <= n_sh_addr;
        r_wr_pend <= n_wr_pend;
        r_wr_addr <= n_wr_addr;
        r_st      <= n_st;
        r_found   <= n_found;
        if (req_xfer) begin
            r_op  <= i_req.operation;
            r_key <= i_req.key;
            r_val <= i_req.entry_value;
        end
        if (out_load) begin
            r_o_st    <= r_st;
            r_o_pos   <= pos_ext[SKT_POS_W-1:0];
            r_o_found <= r_found;
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_st;
    assign o_rsp.position    = r_o_pos;
    assign o_rsp.found_value = r_o_found;
endmodule

@@ hw/rtl/skt_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
